// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, sampled on the rising edge of clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ptat_pkg.sv =====
package ptat_pkg;

	// Table geometry
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Field widths
	localparam int ADDR_W     = 32;
	localparam int IN_IDX_W   = 6;
	localparam int PAGE_W     = 22;
	localparam int OFFS_W     = 31;
	localparam int FRAME_W    = 32;
	localparam int OB_W       = 5;
	localparam int STATUS_W   = 2;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 88;

	// Offset width lower limit and reset value
	localparam logic [OB_W-1:0] MIN_OB   = 5'd10;
	localparam logic [OB_W-1:0] OB_RESET = 5'd12;

	// Item kinds
	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_WRITE     = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd3;

	// Transaction travelling along the cell chain
	typedef struct packed {
		logic                valid;
		logic                write;
		logic [IN_IDX_W-1:0] idx;
		logic [PAGE_W-1:0]   page;
		logic                present;
		logic [FRAME_W-1:0]  data;       // frame for a write, page offset for a lookup
		logic                found;
		logic                hit_present;
		logic [FRAME_W-1:0]  res_frame;
	} tok_t;

	// Compare a slot index from the item with a cell position
	function automatic logic idx_match(logic [IN_IDX_W-1:0] a, logic [IDX_W-1:0] b);
		return int'(a) == int'(b);
	endfunction

endpackage

// ===== hw/rtl/ptat_cell.sv =====
module ptat_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [ptat_pkg::IDX_W-1:0] position,
	input  ptat_pkg::tok_t            tok_in,
	output ptat_pkg::tok_t            tok_out
);

	logic                            slot_valid_q;
	logic [ptat_pkg::PAGE_W-1:0]     slot_page_q;
	logic                            slot_present_q;
	logic [ptat_pkg::FRAME_W-1:0]    slot_frame_q;
	ptat_pkg::tok_t                  tok_q;
	ptat_pkg::tok_t                  tok_nxt;
	logic                            hit;
	logic                            wr;

	// Match a lookup against this slot; the first match along the chain wins
	assign hit = tok_in.valid && !tok_in.write && !tok_in.found && slot_valid_q &&
		(slot_page_q == tok_in.page);
	assign wr = tok_in.valid && tok_in.write && ptat_pkg::idx_match(tok_in.idx, position);

	always_comb begin
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.found       = 1'b1;
			tok_nxt.hit_present = slot_present_q;
			tok_nxt.res_frame   = slot_present_q ? slot_frame_q : '0;
		end
	end

	// Hand the transaction on and mark the slot valid on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q        <= '0;
			slot_valid_q <= 1'b0;
		end else if (adv) begin
			tok_q <= tok_nxt;
			if (wr) begin
				slot_valid_q <= 1'b1;
			end
		end
	end

	// Load the slot contents on a write
	always_ff @(posedge clk) begin
		if (adv && wr) begin
			slot_page_q    <= tok_in.page;
			slot_present_q <= tok_in.present;
			slot_frame_q   <= tok_in.data;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/page_table_address_translator_unit.sv =====
// Channel   Dir  Contents
// s_*       in   tuser: op; tdata: address, entry_index, entry_page, entry_present,
//                entry_frame
// m_*       out  tuser: status; tdata: page_number, page_offset, frame_number
// cfg_*     in   offset_bits, written when cfg_we is high
//
// One transaction enters per cycle while s_tready is high; each result passes through the
// chain of one compare cell per table slot (the first cell loads at the accepting edge)
// and then the output register.
// Writes and lookups keep their order as they travel the chain.
// Reset clears the slot valid marks, the chain and the output valid flag at once.
// A stalled result holds the whole chain, and s_tready falls with it.
`include "assert_macros.svh"

module page_table_address_translator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ptat_pkg::OB_W-1:0]           cfg_wdata,    // offset_bits
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [31:0] address, [37:32] entry_index, [59:38] entry_page, [60] entry_present,
	// [92:61] entry_frame, [95:93] zero
	input  logic [ptat_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                s_tuser,      // [0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [21:0] page_number, [52:22] page_offset, [84:53] frame_number, [87:85] zero
	output logic [ptat_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [ptat_pkg::STATUS_W-1:0]       m_tuser       // [1:0] status
);

	logic [ptat_pkg::OB_W-1:0]     offset_bits_q;
	logic [ptat_pkg::OB_W-1:0]     eff_ob;
	logic [ptat_pkg::ADDR_W-1:0]   address;
	logic [ptat_pkg::ADDR_W-1:0]   offs_mask;
	logic                          adv;
	ptat_pkg::tok_t                chain [0:ptat_pkg::ENTRIES];
	ptat_pkg::tok_t                last;
	logic                          m_tvalid_q;
	logic [ptat_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [ptat_pkg::STATUS_W-1:0] m_tuser_q;
	logic [ptat_pkg::STATUS_W-1:0] status;
	logic [ptat_pkg::PAGE_W-1:0]   res_page;
	logic [ptat_pkg::OFFS_W-1:0]   res_offs;
	logic [ptat_pkg::FRAME_W-1:0]  res_frame;

	// Hold the offset width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= ptat_pkg::OB_RESET;
		end else if (cfg_we) begin
			offset_bits_q <= cfg_wdata;
		end
	end

	// Advance the chain whenever the output register is free or being emptied
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	// Split the address into page number and offset
	assign address   = s_tdata[31:0];
	assign eff_ob    = (offset_bits_q < ptat_pkg::MIN_OB) ? ptat_pkg::MIN_OB : offset_bits_q;
	assign offs_mask = ~({ptat_pkg::ADDR_W{1'b1}} << eff_ob);

	// Build the transaction entering the first cell
	always_comb begin
		chain[0]             = '0;
		chain[0].valid       = s_tvalid;
		chain[0].write       = (s_tuser == ptat_pkg::OP_WRITE);
		chain[0].idx         = s_tdata[37:32];
		chain[0].present     = s_tdata[60];
		if (s_tuser == ptat_pkg::OP_WRITE) begin
			chain[0].page = s_tdata[59:38];
			chain[0].data = s_tdata[92:61];
		end else begin
			chain[0].page = ptat_pkg::PAGE_W'(address >> eff_ob);
			chain[0].data = address & offs_mask;
		end
	end

	// One compare cell per table slot
	for (genvar i = 0; i < ptat_pkg::ENTRIES; i++) begin : g_cell
		ptat_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.position (ptat_pkg::IDX_W'(i)),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	// Form the result from the transaction leaving the chain
	assign last = chain[ptat_pkg::ENTRIES];

	always_comb begin
		if (last.write) begin
			status    = ptat_pkg::ST_WRITTEN;
			res_page  = '0;
			res_offs  = '0;
			res_frame = '0;
		end else begin
			res_page = last.page;
			res_offs = last.data[ptat_pkg::OFFS_W-1:0];
			if (!last.found) begin
				status    = ptat_pkg::ST_MISSING;
				res_frame = '0;
			end else if (last.hit_present) begin
				status    = ptat_pkg::ST_OK;
				res_frame = last.res_frame;
			end else begin
				status    = ptat_pkg::ST_ABSENT;
				res_frame = '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tuser_q <= status;
			m_tdata_q <= {3'b000, res_frame, res_offs, res_page};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Checks
	`ASSERT_SAME(a_stall_only_when_full, !s_tready, m_tvalid, "input stalled with no result waiting")
	`ASSERT_SAME(a_write_result_zero, m_tvalid && (m_tuser == ptat_pkg::ST_WRITTEN), m_tdata == '0, "write result carries data")
	`ASSERT_SAME(a_frame_only_on_ok, m_tvalid && (m_tuser != ptat_pkg::ST_OK), m_tdata[84:53] == '0, "frame set on failed lookup")
	`ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(chain[ptat_pkg::ENTRIES]), "chain moved during stall")

endmodule
